// ===== sv/ucb1_bandit_arm_selector_unit_macros.svh =====
// assertion macros for the ucb1 arm selector checker
`ifndef UCB1_BANDIT_ARM_SELECTOR_UNIT_MACROS_SVH
`define UCB1_BANDIT_ARM_SELECTOR_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define UCB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define UCB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/ucb1_pkg.sv =====
// ---------------------------------------------------------------------------
// ucb1_pkg
// shared constants and types of the ucb1 arm selector
// ---------------------------------------------------------------------------
package ucb1_pkg;
  localparam int MaxArms = 64;
  localparam int ArmW    = $clog2(MaxArms);
  localparam int CntW    = $clog2(MaxArms) + 1;
  localparam logic [15:0] Ln2Q16 = 16'd45426;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_REWARD = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    CFG_NUM_ARMS = 1'b0,
    CFG_EXPL_C   = 1'b1
  } cfg_idx_e;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage

// ===== sv/ucb1_div.sv =====
// ---------------------------------------------------------------------------
// ucb1_div
// radix-2 restoring divider, 64 by 32 bits, one quotient bit per cycle
// ---------------------------------------------------------------------------
module ucb1_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ucb1_pkg::div_req_t req_i,
  output ucb1_pkg::div_rsp_t rsp_o
);
  import ucb1_pkg::*;

  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;
  logic [33:0] diff;

  always_comb begin
    trial  = {rem_q[31:0], quo_q[63]};
    diff   = {1'b0, trial} - {2'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_d = diff[32:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// ===== sv/ucb1_sqrt.sv =====
// ---------------------------------------------------------------------------
// ucb1_sqrt
// bit-pair floor square root of a 64-bit value, one result bit per cycle
// ---------------------------------------------------------------------------
module ucb1_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import ucb1_pkg::*;

  logic [63:0] v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [63:0] sum;

  always_comb begin
    sum    = res_q + bit_q;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = val_i;
      res_d  = '0;
      bit_d  = 64'h4000_0000_0000_0000;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q >= sum) begin
        v_d   = v_q - sum;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];
endmodule

// ===== sv/ucb1_bandit_arm_selector_unit.sv =====
// ---------------------------------------------------------------------------
// ucb1_bandit_arm_selector_unit
// ucb1 arm selector with shared divider and root unit
// ---------------------------------------------------------------------------
// Input words (kind, reward) arrive on in_valid_i/in_ready_o. Kind 0 clears
// all statistics and answers arm 0; kind 1 credits the reward to the last
// chosen arm and answers the next arm; kind 2 answers the most-visited arm
// with is_answer set; kind 3 is dropped without a result.
// Result words leave on out_valid_o/out_ready_i from an output register.
// Configuration words (cfg_index_i, cfg_data_i) are taken whenever offered.
// A start needs a clearing sweep over all 64 entries of both tables.
// A finish scans the arms in use, reading and comparing each in turn.
// A reward scans the arms; each visited arm takes two passes through
// the divider (mean and ln ratio) and one through the root unit.
// One item at a time: in_ready_o is low while an item is processed or
// its result waits. After reset the statistics sweep clears both tables
// before the first item is taken. A stalled receiver holds the result
// and keeps the block from taking the next item.
// ---------------------------------------------------------------------------
module ucb1_bandit_arm_selector_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic signed [10:0] reward_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  arm_o,
  output logic        is_answer_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import ucb1_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_UPDRD  = 11'b000_0000_0100,
    S_UPDWR  = 11'b000_0000_1000,
    S_LN     = 11'b000_0001_0000,
    S_RD     = 11'b000_0010_0000,
    S_CHK    = 11'b000_0100_0000,
    S_DMEAN  = 11'b000_1000_0000,
    S_DRAT   = 11'b001_0000_0000,
    S_ROOT   = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] visits_mem [MaxArms];
  logic [47:0] sum_mem    [MaxArms];
  logic [31:0] vis_rd_q;
  logic [47:0] sum_rd_q;
  logic        we;
  logic [ArmW-1:0] waddr, raddr;
  logic [31:0] wvis;
  logic [47:0] wsum;

  logic [6:0]  num_arms_q;
  logic [15:0] expl_q;
  logic [31:0] total_q;
  logic [ArmW-1:0] last_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] n_use;
  logic        finish_q, finish_d, unvisit_q, unvisit_d;
  logic [ArmW-1:0] best_q, best_d;
  logic signed [64:0] best_sc_q, best_sc_d;
  logic [31:0] most_q, most_d;
  logic        have_q, have_d;
  logic [63:0] ln_q, ln_d;
  logic signed [64:0] mean_q, mean_d;
  logic        neg_q, neg_d;
  logic [5:0]  arm_q, arm_d;
  logic        ans_q, ans_d;
  logic        ov_q, ov_d;
  logic signed [10:0] reward_q, reward_d;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic        sq_start;
  logic [63:0] sq_val;
  logic        sq_done;
  logic [31:0] sq_root;

  ucb1_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  ucb1_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(sq_start), .val_i(sq_val),
                    .done_o(sq_done), .root_o(sq_root));

  // arms in use, clamped to 1..MaxArms
  always_comb begin
    if (num_arms_q == '0) n_use = CntW'(1);
    else if ({25'd0, num_arms_q} > 32'(MaxArms)) n_use = CntW'(MaxArms);
    else n_use = CntW'(num_arms_q);
  end

  // leading-one log and ln, combinational over the 32-bit total
  logic [4:0]  lz_p;
  logic [47:0] ln_shift;
  logic [36:0] log2v;
  logic [52:0] ln_prod;
  always_comb begin
    lz_p = '0;
    for (int i = 0; i < 32; i++) begin
      if (total_q[i]) lz_p = 5'(i);
    end
    ln_shift = ({16'd0, total_q} << 16) >> lz_p;
    log2v    = {16'd0, lz_p, 16'd0} + {5'd0, ln_shift[31:0]} - 37'd65536;
    ln_prod  = log2v * Ln2Q16;
  end

  logic [47:0] mag;
  logic signed [48:0] upd_sum;
  logic signed [64:0] score;
  logic [47:0] bonus_full;

  always_comb begin
    mag        = sum_rd_q[47] ? (~sum_rd_q + 48'd1) : sum_rd_q;
    upd_sum    = 49'(signed'(sum_rd_q)) + 49'(reward_q);
    bonus_full = ({16'd0, sq_root} * {32'd0, expl_q}) >> 12;
    score      = mean_q + 65'(bonus_full);
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    finish_d  = finish_q;
    unvisit_d = unvisit_q;
    best_d    = best_q;
    best_sc_d = best_sc_q;
    most_d    = most_q;
    have_d    = have_q;
    ln_d      = ln_q;
    mean_d    = mean_q;
    neg_d     = neg_q;
    arm_d     = arm_q;
    ans_d     = ans_q;
    ov_d      = ov_q;
    reward_d  = reward_q;
    we        = 1'b0;
    waddr     = idx_q[ArmW-1:0];
    wvis      = '0;
    wsum      = '0;
    raddr     = idx_q[ArmW-1:0];
    div_req   = '0;
    sq_start  = 1'b0;
    sq_val    = '0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        idx_d = idx_q + CntW'(1);
        if (idx_q == CntW'(MaxArms - 1)) begin
          idx_d = '0;
          if (finish_q) begin
            arm_d = '0; ans_d = 1'b0; ov_d = 1'b1;
            finish_d = 1'b0;
            state_d = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_e'(kind_i))
            KIND_START: begin
              idx_d = '0; finish_d = 1'b1; state_d = S_CLEAR;
            end
            KIND_REWARD: begin
              reward_d = reward_i;
              raddr = last_q; state_d = S_UPDRD;
            end
            KIND_FINISH: begin
              idx_d = '0; finish_d = 1'b1; most_d = '0; best_d = '0;
              raddr = '0; state_d = S_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_UPDRD: begin
        raddr   = last_q;
        state_d = S_UPDWR;
      end
      S_UPDWR: begin
        we    = 1'b1;
        waddr = last_q;
        wvis  = (vis_rd_q == '1) ? vis_rd_q : vis_rd_q + 32'd1;
        if (upd_sum > 49'sh0_7FFF_FFFF_FFFF) wsum = 48'h7FFF_FFFF_FFFF;
        else if (upd_sum < -49'sh0_8000_0000_0000) wsum = 48'h8000_0000_0000;
        else wsum = upd_sum[47:0];
        state_d = S_LN;
      end
      S_LN: begin
        ln_d      = (total_q == '0) ? '0 : 64'(ln_prod >> 16);
        idx_d     = '0;
        finish_d  = 1'b0;
        unvisit_d = 1'b1;
        have_d    = 1'b0;
        best_d    = '0;
        raddr     = '0;
        state_d   = S_RD;
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (finish_q) begin
          if (vis_rd_q > most_q) begin
            most_d = vis_rd_q; best_d = idx_q[ArmW-1:0];
          end
          idx_d = idx_q + CntW'(1);
          raddr = idx_d[ArmW-1:0];
          state_d = S_RD;
          if (idx_d == n_use) begin
            arm_d = (vis_rd_q > most_q) ? idx_q[ArmW-1:0] : best_q;
            ans_d = 1'b1; ov_d = 1'b1; finish_d = 1'b0;
            state_d = S_OUT;
          end
        end else if (unvisit_q) begin
          idx_d = idx_q + CntW'(1);
          raddr = idx_d[ArmW-1:0];
          state_d = S_RD;
          if (vis_rd_q == '0) begin
            arm_d = idx_q[ArmW-1:0]; ans_d = 1'b0; ov_d = 1'b1;
            state_d = S_OUT;
          end else if (idx_d == n_use) begin
            unvisit_d = 1'b0; idx_d = '0; raddr = '0;
          end
        end else begin
          neg_d = sum_rd_q[47];
          div_req.start    = 1'b1;
          div_req.dividend = {mag, 16'd0};
          div_req.divisor  = vis_rd_q;
          state_d = S_DMEAN;
        end
      end
      S_DMEAN: begin
        if (div_rsp.done) begin
          mean_d = neg_q ? -65'(div_rsp.quotient) : 65'(div_rsp.quotient);
          div_req.start    = 1'b1;
          div_req.dividend = ln_q;
          div_req.divisor  = vis_rd_q;
          state_d = S_DRAT;
        end
      end
      S_DRAT: begin
        if (div_rsp.done) begin
          sq_start = 1'b1;
          sq_val   = {div_rsp.quotient[47:0], 16'd0};
          state_d  = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sq_done) begin
          if (!have_q || score > best_sc_q) begin
            best_sc_d = score; best_d = idx_q[ArmW-1:0]; have_d = 1'b1;
          end
          idx_d = idx_q + CntW'(1);
          raddr = idx_d[ArmW-1:0];
          state_d = S_RD;
          if (idx_d == n_use) begin
            arm_d = (!have_q || score > best_sc_q) ? idx_q[ArmW-1:0] : best_q;
            ans_d = 1'b0; ov_d = 1'b1;
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          ov_d = 1'b0; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // bookkeeping of total and last arm: cleared by a start, advanced by rewards
  logic [31:0] total_d;
  logic [ArmW-1:0] last_d;
  always_comb begin
    total_d = total_q;
    last_d  = last_q;
    if (state_q == S_IDLE && in_valid_i && kind_e'(kind_i) == KIND_START) begin
      total_d = '0; last_d = '0;
    end
    if (state_q == S_UPDWR && total_q != '1) total_d = total_q + 32'd1;
    if (ov_d && !ov_q && !ans_d) last_d = arm_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      visits_mem[waddr] <= wvis;
      sum_mem[waddr]    <= wsum;
    end
    vis_rd_q <= visits_mem[raddr];
    sum_rd_q <= sum_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      idx_q      <= '0;
      finish_q   <= 1'b0;
      unvisit_q  <= 1'b0;
      have_q     <= 1'b0;
      ov_q       <= 1'b0;
      total_q    <= '0;
      last_q     <= '0;
      num_arms_q <= 7'd2;
      expl_q     <= 16'd5793;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      finish_q  <= finish_d;
      unvisit_q <= unvisit_d;
      have_q    <= have_d;
      ov_q      <= ov_d;
      total_q   <= total_d;
      last_q    <= last_d;
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_NUM_ARMS: num_arms_q <= cfg_data_i[6:0];
          CFG_EXPL_C:   expl_q     <= cfg_data_i;
          default:      num_arms_q <= num_arms_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q    <= best_d;
    best_sc_q <= best_sc_d;
    most_q    <= most_d;
    ln_q      <= ln_d;
    mean_q    <= mean_d;
    neg_q     <= neg_d;
    arm_q     <= arm_d;
    ans_q     <= ans_d;
    reward_q  <= reward_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign arm_o       = arm_q;
  assign is_answer_o = ans_q;
endmodule

// ===== sv/ucb1_checker.sv =====
// ---------------------------------------------------------------------------
// ucb1_checker
// port-level checks of the ucb1 arm selector handshakes
// ---------------------------------------------------------------------------
`include "ucb1_bandit_arm_selector_unit_macros.svh"
module ucb1_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [5:0] arm_o,
  input logic       is_answer_o
);
  // one item at a time: no new word while a result is pending
  `UCB_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o, "ready with result pending")
  // a stalled result holds
  `UCB_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(arm_o) && $stable(is_answer_o), "result changed under stall")
  // an accepted word never yields a result in the very next cycle
  `UCB_ASSERT_NXT(a_lat, clk_i, rst_ni, in_valid_i && in_ready_o, !out_valid_o, "result too early")
endmodule

bind ucb1_bandit_arm_selector_unit ucb1_checker u_ucb1_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .arm_o, .is_answer_o
);

// ===== tb/tb_ucb1_bandit_arm_selector_unit.sv =====
// ---------------------------------------------------------------------------
// tb_ucb1_bandit_arm_selector_unit
// self-checking bench for the ucb1 arm selector: a queue-fed driver, a
// monitor, and a bit-exact score predictor; phases over several arm counts
// and exploration constants, with directed words first and random
// start/reward/finish sequences with noise words after
// ---------------------------------------------------------------------------
module tb_ucb1_bandit_arm_selector_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ucb1_pkg::*;

  typedef struct {
    kind_e             kind;
    logic signed [10:0] reward;
  } bandit_word_t;

  typedef struct {
    logic [5:0] arm;
    logic       is_answer;
  } arm_choice_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_START;
  logic signed [10:0] reward_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  arm_o;
  logic        is_answer_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_NUM_ARMS;
  logic [15:0] cfg_data_i = '0;

  ucb1_bandit_arm_selector_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [6:0]   pred_num_arms = 7'd2;
  logic [15:0]  pred_expl_c = 16'd5793;
  int unsigned  arm_visits[MaxArms];
  longint       arm_sums[MaxArms];
  int unsigned  total_visits;
  int unsigned  last_arm;

  bandit_word_t words_pending[$];
  arm_choice_t  choices_expected[$];
  bit           failed = 1'b0;
  bit           quiet = 1'b0;

  function automatic int unsigned arms_in_use();
    int unsigned n;
    n = pred_num_arms;
    if (n == 0) n = 1;
    if (n > MaxArms) n = MaxArms;
    return n;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] ln_fixed(int unsigned t);
    int unsigned p;
    logic [63:0] l2;
    if (t == 0) return 64'd0;
    p = 0;
    while (p < 31 && (t >> (p + 1)) != 0) p++;
    l2 = 64'(p) * 64'd65536 + (((64'(t) << 16) >> p) - 64'd65536);
    return (l2 * 64'(Ln2Q16)) >> 16;
  endfunction

  function automatic longint arm_score(int unsigned a);
    logic [63:0] mag, ratio, root, bonus;
    longint s, mean;
    if (arm_visits[a] == 0) return 0;
    s = arm_sums[a];
    mag = (s < 0) ? 64'(-s) : 64'(s);
    mag = (mag << 16) / 64'(arm_visits[a]);
    mean = (s < 0) ? -longint'(mag) : longint'(mag);
    ratio = ln_fixed(total_visits) / 64'(arm_visits[a]);
    root = floor_sqrt(ratio << 16);
    bonus = (64'(pred_expl_c) * root) >> 12;
    return mean + longint'(bonus);
  endfunction

  function automatic int unsigned next_arm();
    int unsigned n, best;
    longint best_sc, sc;
    n = arms_in_use();
    for (int unsigned a = 0; a < n; a++)
      if (arm_visits[a] == 0) return a;
    best = 0;
    best_sc = arm_score(0);
    for (int unsigned a = 1; a < n; a++) begin
      sc = arm_score(a);
      if (sc > best_sc) begin
        best_sc = sc;
        best = a;
      end
    end
    return best;
  endfunction

  function automatic void clear_stats();
    for (int a = 0; a < MaxArms; a++) begin
      arm_visits[a] = 0;
      arm_sums[a] = 0;
    end
    total_visits = 0;
    last_arm = 0;
  endfunction

  function automatic void predict_choice(bandit_word_t w);
    arm_choice_t c;
    longint s;
    int unsigned n, most;
    c.arm = '0;
    c.is_answer = 1'b0;
    case (w.kind)
      KIND_START: begin
        clear_stats();
        choices_expected.push_back(c);
      end
      KIND_REWARD: begin
        s = arm_sums[last_arm] + longint'(w.reward);
        if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
        if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
        arm_sums[last_arm] = s;
        if (arm_visits[last_arm] != 32'hFFFF_FFFF) arm_visits[last_arm]++;
        if (total_visits != 32'hFFFF_FFFF) total_visits++;
        last_arm = next_arm();
        c.arm = last_arm[5:0];
        choices_expected.push_back(c);
      end
      KIND_FINISH: begin
        n = arms_in_use();
        most = 0;
        for (int unsigned a = 0; a < n; a++)
          if (arm_visits[a] > most) begin
            most = arm_visits[a];
            c.arm = a[5:0];
          end
        c.is_answer = 1'b1;
        choices_expected.push_back(c);
      end
      default: ;
    endcase
  endfunction

  // driver
  int     in_gap = 0;
  bit     drv_busy;
  bandit_word_t drv_w;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      drv_busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        drv_w.kind = kind_e'(kind_i);
        drv_w.reward = reward_i;
        predict_choice(drv_w);
        drv_busy = 1'b0;
        in_gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
      if (!drv_busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (words_pending.size() > 0) begin
          drv_w = words_pending.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= drv_w.kind;
          reward_i <= drv_w.reward;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  int results_seen = 0;
  arm_choice_t mon_c;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (choices_expected.size() == 0) begin
          $display("%0t: unexpected word arm=%0d is_answer=%0b", $time, arm_o, is_answer_o);
          failed = 1'b1;
        end else begin
          mon_c = choices_expected.pop_front();
          if (arm_o !== mon_c.arm) begin
            $display("%0t: arm expected %0d actual %0d", $time, mon_c.arm, arm_o);
            failed = 1'b1;
          end
          if (is_answer_o !== mon_c.is_answer) begin
            $display("%0t: is_answer expected %0b actual %0b", $time, mon_c.is_answer,
                     is_answer_o);
            failed = 1'b1;
          end
        end
        results_seen++;
        out_gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        // long hold-off so the block backs up into its input
        if (results_seen == 100) out_gap = 3000;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_NUM_ARMS) pred_num_arms = d[6:0];
    else pred_expl_c = d;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (words_pending.size() != 0 || in_valid_i || choices_expected.size() != 0)
      @(posedge clk_i);
    // a dropped kind 3 word may still be in flight
    repeat (40) @(posedge clk_i);
  endtask

  function automatic void add_word(kind_e k, int r);
    bandit_word_t w;
    w.kind = k;
    w.reward = 11'(r);
    words_pending.push_back(w);
  endfunction

  function automatic int rand_reward();
    case ($urandom_range(0, 5))
      0: return 1023;
      1: return -1024;
      2: return $urandom_range(0, 20) - 10;
      default: return $urandom_range(0, 2047) - 1024;
    endcase
  endfunction

  // one search: usually a start, rewards broken up by noise and finishes, usually a finish
  function automatic int add_search(int unsigned n);
    int cnt, len;
    cnt = 0;
    if ($urandom_range(0, 9) != 0) begin add_word(KIND_START, $urandom); cnt++; end
    len = $urandom_range(0, 3 * n + 5);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) add_word(KIND_NONE, $urandom);
      else if ($urandom_range(0, 29) == 0) add_word(KIND_FINISH, $urandom);
      else add_word(KIND_REWARD, rand_reward());
      cnt++;
    end
    if ($urandom_range(0, 7) != 0) begin add_word(KIND_FINISH, $urandom); cnt++; end
    return cnt;
  endfunction

  int unsigned ph_arms[10] = '{2, 1, 64, 0, 3, 127, 5, 8, 4, 6};
  int          ph_c[10];
  int          ph_items;
  int          ph_target;

  initial begin
    ph_c = '{5793, 0, 65535, 4096, 1, 12345, 5793, 65535, 0, 8192};
    clear_stats();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words
    write_reg(CFG_NUM_ARMS, 16'd2);
    write_reg(CFG_EXPL_C, 16'd5793);
    add_word(KIND_FINISH, 0);
    add_word(KIND_REWARD, 1023);
    add_word(KIND_START, 0);
    add_word(KIND_FINISH, 0);
    add_word(KIND_NONE, 0);
    add_word(KIND_REWARD, 1023);
    add_word(KIND_REWARD, -1024);
    add_word(KIND_REWARD, 0);
    add_word(KIND_REWARD, -1);
    add_word(KIND_NONE, -1);
    add_word(KIND_REWARD, 1);
    add_word(KIND_FINISH, 0);
    add_word(KIND_REWARD, 511);
    add_word(KIND_FINISH, 0);
    add_word(KIND_START, -1);
    add_word(KIND_REWARD, -512);
    add_word(KIND_FINISH, 0);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_NUM_ARMS, 16'(ph_arms[ph]));
      write_reg(CFG_EXPL_C, (ph >= 6) ? 16'($urandom) : 16'(ph_c[ph]));
      quiet = (ph % 3 == 1);
      ph_target = (arms_in_use() > 8) ? 80 : 200;
      // rewards first: may land on a last arm beyond the new arm count
      add_word(KIND_REWARD, rand_reward());
      add_word(KIND_REWARD, rand_reward());
      ph_items = 2;
      while (ph_items < ph_target) ph_items += add_search(arms_in_use());
      wait_idle();
    end

    repeat (300) @(posedge clk_i);
    if (!failed) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #500_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
